[design/tsst_pkg.sv]
// ----------------------------------------------------------------------------
// Tray slot status tracker package
// Field widths, slot and request codes, control word layout and the
// sequencer program with its entry table.
// ----------------------------------------------------------------------------
package tsst_pkg;

  localparam int FIELD_W = 11;
  localparam int ACT_W   = 4;
  localparam int ST_W    = 2;
  localparam int PC_W    = 6;

  // slot status
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd0;
  localparam logic [ST_W-1:0] ST_BOOKED = 2'd1;
  localparam logic [ST_W-1:0] ST_MOVING = 2'd2;
  localparam logic [ST_W-1:0] ST_DONE   = 2'd3;

  // requests
  localparam logic [ACT_W-1:0] ACT_QUERY       = 4'd0;
  localparam logic [ACT_W-1:0] ACT_BOOK        = 4'd1;
  localparam logic [ACT_W-1:0] ACT_DONE_NOW    = 4'd2;
  localparam logic [ACT_W-1:0] ACT_DONE_AT     = 4'd3;
  localparam logic [ACT_W-1:0] ACT_MOVE_NOW    = 4'd4;
  localparam logic [ACT_W-1:0] ACT_MOVE_AT     = 4'd5;
  localparam logic [ACT_W-1:0] ACT_ALL_DONE    = 4'd6;
  localparam logic [ACT_W-1:0] ACT_SET_FULL    = 4'd7;
  localparam logic [ACT_W-1:0] ACT_CHANGE_TRAY = 4'd8;
  localparam logic [ACT_W-1:0] ACT_LOT_DONE    = 4'd9;
  localparam logic [ACT_W-1:0] ACT_READ_STATUS = 4'd10;
  localparam logic [ACT_W-1:0] ACT_READ_SKIP   = 4'd11;
  localparam logic [ACT_W-1:0] ACT_SET_SKIP    = 4'd12;
  localparam logic [ACT_W-1:0] ACT_RESTORE     = 4'd13;
  localparam logic [ACT_W-1:0] ACT_SET_NEXT    = 4'd14;
  localparam logic [ACT_W-1:0] ACT_CHECK       = 4'd15;

  // memory address source
  localparam logic [1:0] A_PTR = 2'd0;
  localparam logic [1:0] A_IDX = 2'd1;
  localparam logic [1:0] A_CUR = 2'd2;
  localparam logic [1:0] A_NXT = 2'd3;

  // loop limit source
  localparam logic [1:0] LIM_N   = 2'd0;
  localparam logic [1:0] LIM_RST = 2'd1;
  localparam logic [1:0] LIM_MAX = 2'd2;

  // jump conditions
  localparam logic [2:0] C_NEXT      = 3'd0;
  localparam logic [2:0] C_JUMP      = 3'd1;
  localparam logic [2:0] C_END       = 3'd2;
  localparam logic [2:0] C_MORE      = 3'd3;
  localparam logic [2:0] C_MISS_FREE = 3'd4;
  localparam logic [2:0] C_MISS_DM   = 3'd5;
  localparam logic [2:0] C_BAD       = 3'd6;

  // pointer updates
  localparam logic [3:0] U_NONE      = 4'd0;
  localparam logic [3:0] U_CUR_NXT   = 4'd1;
  localparam logic [3:0] U_NXT_INC   = 4'd2;
  localparam logic [3:0] U_AT        = 4'd3;
  localparam logic [3:0] U_NXT_PTRM1 = 4'd4;
  localparam logic [3:0] U_ALL_DONE  = 4'd5;
  localparam logic [3:0] U_NXT_N     = 4'd6;
  localparam logic [3:0] U_ZERO      = 4'd7;
  localparam logic [3:0] U_NXT_IDX   = 4'd8;

  // result flag set
  localparam logic [1:0] RES_NONE = 2'd0;
  localparam logic [1:0] RES_EOT  = 2'd1;
  localparam logic [1:0] RES_ERR  = 2'd2;
  localparam logic [1:0] RES_FLAG = 2'd3;

  // read data capture
  localparam logic [1:0] LAT_NONE  = 2'd0;
  localparam logic [1:0] LAT_STATE = 2'd1;
  localparam logic [1:0] LAT_SKIP  = 2'd2;

  // program addresses
  localparam logic [PC_W-1:0] S_CLR     = 6'd0;
  localparam logic [PC_W-1:0] S_CLR_END = 6'd1;
  localparam logic [PC_W-1:0] S_FIN     = 6'd2;
  localparam logic [PC_W-1:0] S_ERR     = 6'd3;
  localparam logic [PC_W-1:0] S_Q0      = 6'd4;
  localparam logic [PC_W-1:0] S_Q1      = 6'd5;
  localparam logic [PC_W-1:0] S_QHIT    = 6'd6;
  localparam logic [PC_W-1:0] S_QEOT    = 6'd7;
  localparam logic [PC_W-1:0] S_BK0     = 6'd8;
  localparam logic [PC_W-1:0] S_BK1     = 6'd9;
  localparam logic [PC_W-1:0] S_DN0     = 6'd10;
  localparam logic [PC_W-1:0] S_DN1     = 6'd11;
  localparam logic [PC_W-1:0] S_DA0     = 6'd12;
  localparam logic [PC_W-1:0] S_DA1     = 6'd13;
  localparam logic [PC_W-1:0] S_MN0     = 6'd14;
  localparam logic [PC_W-1:0] S_MN1     = 6'd15;
  localparam logic [PC_W-1:0] S_MA0     = 6'd16;
  localparam logic [PC_W-1:0] S_MA1     = 6'd17;
  localparam logic [PC_W-1:0] S_AD0     = 6'd18;
  localparam logic [PC_W-1:0] S_AD1     = 6'd19;
  localparam logic [PC_W-1:0] S_SF0     = 6'd20;
  localparam logic [PC_W-1:0] S_SF1     = 6'd21;
  localparam logic [PC_W-1:0] S_CT0     = 6'd22;
  localparam logic [PC_W-1:0] S_CT1     = 6'd23;
  localparam logic [PC_W-1:0] S_LD0     = 6'd24;
  localparam logic [PC_W-1:0] S_LD1     = 6'd25;
  localparam logic [PC_W-1:0] S_RS0     = 6'd26;
  localparam logic [PC_W-1:0] S_RS1     = 6'd27;
  localparam logic [PC_W-1:0] S_RK0     = 6'd28;
  localparam logic [PC_W-1:0] S_RK1     = 6'd29;
  localparam logic [PC_W-1:0] S_SK0     = 6'd30;
  localparam logic [PC_W-1:0] S_SK1     = 6'd31;
  localparam logic [PC_W-1:0] S_RE0     = 6'd32;
  localparam logic [PC_W-1:0] S_RE1     = 6'd33;
  localparam logic [PC_W-1:0] S_SN0     = 6'd34;
  localparam logic [PC_W-1:0] S_SN1     = 6'd35;
  localparam logic [PC_W-1:0] S_K0      = 6'd36;
  localparam logic [PC_W-1:0] S_K1      = 6'd37;
  localparam logic [PC_W-1:0] S_K2      = 6'd38;

  typedef struct packed {
    logic [1:0]      addr_sel;
    logic [1:0]      lim_sel;
    logic            st_we;
    logic [ST_W-1:0] st_val;
    logic            sk_we;
    logic            sk_val;
    logic            ptr_inc;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
    logic [3:0]      upd;
    logic [1:0]      res;
    logic [1:0]      lat;
    logic            fin;
    logic            halt;
  } ucw_t;

  function automatic logic [PC_W-1:0] entry(input logic [ACT_W-1:0] act);
    logic [PC_W-1:0] e;
    case (act)
      ACT_QUERY:       e = S_Q0;
      ACT_BOOK:        e = S_BK0;
      ACT_DONE_NOW:    e = S_DN0;
      ACT_DONE_AT:     e = S_DA0;
      ACT_MOVE_NOW:    e = S_MN0;
      ACT_MOVE_AT:     e = S_MA0;
      ACT_ALL_DONE:    e = S_AD0;
      ACT_SET_FULL:    e = S_SF0;
      ACT_CHANGE_TRAY: e = S_CT0;
      ACT_LOT_DONE:    e = S_LD0;
      ACT_READ_STATUS: e = S_RS0;
      ACT_READ_SKIP:   e = S_RK0;
      ACT_SET_SKIP:    e = S_SK0;
      ACT_RESTORE:     e = S_RE0;
      ACT_SET_NEXT:    e = S_SN0;
      default:         e = S_K0;
    endcase
    return e;
  endfunction

  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '0;
    case (pc)
      S_CLR: begin
        w.addr_sel = A_PTR; w.lim_sel = LIM_MAX;
        w.st_we = 1'b1; w.st_val = ST_EMPTY; w.sk_we = 1'b1; w.sk_val = 1'b0;
        w.ptr_inc = 1'b1; w.cond = C_MORE; w.target = S_CLR;
      end
      S_CLR_END: w.halt = 1'b1;
      S_FIN: w.fin = 1'b1;
      S_ERR: begin
        w.res = RES_ERR; w.fin = 1'b1;
      end
      S_Q0: begin
        w.addr_sel = A_PTR; w.lim_sel = LIM_N; w.cond = C_END; w.target = S_QEOT;
      end
      S_Q1: begin
        w.ptr_inc = 1'b1; w.cond = C_MISS_FREE; w.target = S_Q0;
      end
      S_QHIT: begin
        w.upd = U_NXT_PTRM1; w.fin = 1'b1;
      end
      S_QEOT: begin
        w.res = RES_EOT; w.fin = 1'b1;
      end
      S_BK0: begin
        w.addr_sel = A_NXT; w.cond = C_BAD; w.target = S_ERR;
      end
      S_BK1: begin
        w.addr_sel = A_NXT; w.st_we = 1'b1; w.st_val = ST_BOOKED;
        w.upd = U_CUR_NXT; w.fin = 1'b1;
      end
      S_DN0: begin
        w.addr_sel = A_CUR; w.cond = C_BAD; w.target = S_ERR;
      end
      S_DN1: begin
        w.addr_sel = A_CUR; w.st_we = 1'b1; w.st_val = ST_DONE;
        w.upd = U_NXT_INC; w.fin = 1'b1;
      end
      S_DA0: begin
        w.addr_sel = A_IDX; w.cond = C_BAD; w.target = S_ERR;
      end
      S_DA1: begin
        w.addr_sel = A_IDX; w.st_we = 1'b1; w.st_val = ST_DONE;
        w.upd = U_AT; w.fin = 1'b1;
      end
      S_MN0: begin
        w.addr_sel = A_CUR; w.cond = C_BAD; w.target = S_ERR;
      end
      S_MN1: begin
        w.addr_sel = A_CUR; w.st_we = 1'b1; w.st_val = ST_MOVING; w.fin = 1'b1;
      end
      S_MA0: begin
        w.addr_sel = A_IDX; w.cond = C_BAD; w.target = S_ERR;
      end
      S_MA1: begin
        w.addr_sel = A_IDX; w.st_we = 1'b1; w.st_val = ST_MOVING; w.fin = 1'b1;
      end
      S_AD0: begin
        w.addr_sel = A_PTR; w.lim_sel = LIM_N; w.st_we = 1'b1; w.st_val = ST_DONE;
        w.ptr_inc = 1'b1; w.cond = C_MORE; w.target = S_AD0;
      end
      S_AD1: begin
        w.upd = U_ALL_DONE; w.fin = 1'b1;
      end
      S_SF0: begin
        w.addr_sel = A_PTR; w.lim_sel = LIM_N; w.st_we = 1'b1; w.st_val = ST_DONE;
        w.ptr_inc = 1'b1; w.cond = C_MORE; w.target = S_SF0;
      end
      S_SF1: begin
        w.upd = U_NXT_N; w.fin = 1'b1;
      end
      S_CT0: begin
        w.addr_sel = A_PTR; w.lim_sel = LIM_N;
        w.st_we = 1'b1; w.st_val = ST_EMPTY; w.sk_we = 1'b1; w.sk_val = 1'b0;
        w.ptr_inc = 1'b1; w.cond = C_MORE; w.target = S_CT0;
      end
      S_CT1: begin
        w.upd = U_ZERO; w.fin = 1'b1;
      end
      S_LD0: begin
        w.addr_sel = A_PTR; w.lim_sel = LIM_N; w.st_we = 1'b1; w.st_val = ST_DONE;
        w.ptr_inc = 1'b1; w.cond = C_MORE; w.target = S_LD0;
      end
      S_LD1: begin
        w.upd = U_ZERO; w.fin = 1'b1;
      end
      S_RS0: begin
        w.addr_sel = A_IDX; w.cond = C_BAD; w.target = S_ERR;
      end
      S_RS1: begin
        w.lat = LAT_STATE; w.fin = 1'b1;
      end
      S_RK0: begin
        w.addr_sel = A_IDX; w.cond = C_BAD; w.target = S_ERR;
      end
      S_RK1: begin
        w.lat = LAT_SKIP; w.fin = 1'b1;
      end
      S_SK0: begin
        w.addr_sel = A_CUR; w.cond = C_BAD; w.target = S_ERR;
      end
      S_SK1: begin
        w.addr_sel = A_CUR; w.sk_we = 1'b1; w.sk_val = 1'b1; w.fin = 1'b1;
      end
      S_RE0: begin
        w.addr_sel = A_PTR; w.lim_sel = LIM_RST; w.st_we = 1'b1; w.st_val = ST_DONE;
        w.ptr_inc = 1'b1; w.cond = C_MORE; w.target = S_RE0;
      end
      S_RE1: w.fin = 1'b1;
      S_SN0: begin
        w.addr_sel = A_IDX; w.cond = C_BAD; w.target = S_ERR;
      end
      S_SN1: begin
        w.upd = U_NXT_IDX; w.fin = 1'b1;
      end
      S_K0: begin
        w.addr_sel = A_PTR; w.lim_sel = LIM_N; w.cond = C_END; w.target = S_FIN;
      end
      S_K1: begin
        w.ptr_inc = 1'b1; w.cond = C_MISS_DM; w.target = S_K0;
      end
      S_K2: begin
        w.res = RES_FLAG; w.fin = 1'b1;
      end
      default: w.halt = 1'b1;
    endcase
    return w;
  endfunction

endpackage

[design/tray_slot_status_tracker_top.sv]
// ----------------------------------------------------------------------------
// Tray slot status tracker
// Per-slot status and auto-skip store with current and next slot pointers,
// run by a small microprogram over a single-port slot memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result is
// shown for a single cycle with done high, once busy is low again, and
// cannot be held off. Slot-addressed and pointer requests first check the
// addressed slot against the slot count, then act and show the result. Bulk
// requests (all_done, set_full, change_tray, lot_done, restore) write one
// slot per cycle, then show the result. Query and check test one slot at a
// time: each registered memory read must come back before the slot is
// tested and the next one read. After reset and after every slot_count write
// the block clears its whole memory with busy high.
module tray_slot_status_tracker_top #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [tsst_pkg::ACT_W-1:0]   action,
  input  logic [tsst_pkg::FIELD_W-1:0] slot_index,
  input  logic                         slot_count_we,
  input  logic [tsst_pkg::FIELD_W-1:0] slot_count,
  output logic                         done,
  output logic [tsst_pkg::FIELD_W-1:0] position,
  output logic [tsst_pkg::ST_W-1:0]    slot_state,
  output logic                         flag,
  output logic                         end_of_tray,
  output logic                         index_error
);

  localparam int FW = tsst_pkg::FIELD_W;
  localparam int SW = tsst_pkg::ST_W;
  localparam int PCW = tsst_pkg::PC_W;
  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int PW = ($clog2(MAX_SLOTS + 1) > FW) ? $clog2(MAX_SLOTS + 1) : FW;
  localparam logic [FW-1:0] MAX_CLIP = (MAX_SLOTS > 2047) ? {FW{1'b1}} : FW'(MAX_SLOTS);
  localparam logic [PW-1:0] MAX_PW = PW'(MAX_SLOTS);

  logic [SW-1:0] st_mem [MAX_SLOTS];
  logic          sk_mem [MAX_SLOTS];

  logic            active;
  logic [PCW-1:0]  pc;
  logic [PW-1:0]   ptr;
  logic [FW-1:0]   cur;
  logic [FW-1:0]   nxt;
  logic [FW-1:0]   count;
  logic [tsst_pkg::ACT_W-1:0] act_q;
  logic [FW-1:0]   idx_q;
  logic [SW-1:0]   rd_st;
  logic            rd_sk;
  logic [SW-1:0]   state_q;
  logic            flag_q;
  logic            eot_q;
  logic            err_q;
  logic            done_q;

  tsst_pkg::ucw_t  w;
  logic [FW-1:0]   n;
  logic [PW-1:0]   lim;
  logic            lt;
  logic [FW-1:0]   sel;
  logic [PW-1:0]   addr_full;
  logic [AW-1:0]   addr;
  logic            bad;
  logic            take;
  logic            gate;
  logic            st_wr;
  logic            sk_wr;

  always_comb begin
    w = tsst_pkg::ucode(pc);
    n = (count > MAX_CLIP) ? MAX_CLIP : count;
    case (w.lim_sel)
      tsst_pkg::LIM_N:   lim = PW'(n);
      tsst_pkg::LIM_RST: lim = (nxt < n) ? PW'(nxt) : PW'(n);
      default:           lim = MAX_PW;
    endcase
    lt = ptr < lim;
    case (w.addr_sel)
      tsst_pkg::A_IDX: sel = idx_q;
      tsst_pkg::A_CUR: sel = cur;
      tsst_pkg::A_NXT: sel = nxt;
      default:         sel = ptr[FW-1:0];
    endcase
    addr_full = (w.addr_sel == tsst_pkg::A_PTR) ? ptr : PW'(sel);
    addr = addr_full[AW-1:0];
    bad = sel >= n;
    case (w.cond)
      tsst_pkg::C_JUMP:      take = 1'b1;
      tsst_pkg::C_END:       take = !lt;
      tsst_pkg::C_MORE:      take = lt;
      tsst_pkg::C_MISS_FREE: take = !(rd_st == tsst_pkg::ST_EMPTY ||
                                      rd_st == tsst_pkg::ST_MOVING);
      tsst_pkg::C_MISS_DM:   take = !(rd_st == tsst_pkg::ST_DONE ||
                                      rd_st == tsst_pkg::ST_MOVING);
      tsst_pkg::C_BAD:       take = bad;
      default:               take = 1'b0;
    endcase
    gate = (w.addr_sel != tsst_pkg::A_PTR) || lt;
    st_wr = active && w.st_we && gate;
    sk_wr = active && w.sk_we && gate;
  end

  always_ff @(posedge clk) begin
    if (st_wr) begin
      st_mem[addr] <= w.st_val;
    end
    rd_st <= st_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (sk_wr) begin
      sk_mem[addr] <= w.sk_val;
    end
    rd_sk <= sk_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b1;
      pc      <= tsst_pkg::S_CLR;
      ptr     <= '0;
      cur     <= '0;
      nxt     <= '0;
      count   <= '0;
      act_q   <= tsst_pkg::ACT_QUERY;
      state_q <= '0;
      flag_q  <= 1'b0;
      eot_q   <= 1'b0;
      err_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= !slot_count_we && active && w.fin;
      if (slot_count_we) begin
        count  <= slot_count;
        active <= 1'b1;
        pc     <= tsst_pkg::S_CLR;
        ptr    <= '0;
      end else if (!active) begin
        if (start) begin
          active  <= 1'b1;
          pc      <= tsst_pkg::entry(action);
          ptr     <= '0;
          act_q   <= action;
          idx_q   <= slot_index;
          state_q <= '0;
          flag_q  <= 1'b0;
          eot_q   <= 1'b0;
          err_q   <= 1'b0;
        end
      end else begin
        pc <= take ? w.target : pc + PCW'(1);
        if (w.ptr_inc) begin
          ptr <= ptr + PW'(1);
        end
        if (w.fin || w.halt) begin
          active <= 1'b0;
        end
        case (w.res)
          tsst_pkg::RES_EOT:  eot_q <= 1'b1;
          tsst_pkg::RES_ERR:  err_q <= 1'b1;
          tsst_pkg::RES_FLAG: flag_q <= 1'b1;
          default: ;
        endcase
        case (w.lat)
          tsst_pkg::LAT_STATE: state_q <= rd_st;
          tsst_pkg::LAT_SKIP:  flag_q <= rd_sk;
          default: ;
        endcase
        case (w.upd)
          tsst_pkg::U_CUR_NXT:   cur <= nxt;
          tsst_pkg::U_NXT_INC:   nxt <= nxt + FW'(1);
          tsst_pkg::U_AT: begin
            cur <= idx_q;
            nxt <= idx_q + FW'(1);
          end
          tsst_pkg::U_NXT_PTRM1: nxt <= ptr[FW-1:0] - FW'(1);
          tsst_pkg::U_ALL_DONE: begin
            cur <= (n != '0) ? n - FW'(1) : '0;
            nxt <= n;
          end
          tsst_pkg::U_NXT_N:     nxt <= n;
          tsst_pkg::U_ZERO: begin
            cur <= '0;
            nxt <= '0;
          end
          tsst_pkg::U_NXT_IDX:   nxt <= idx_q;
          default: ;
        endcase
      end
    end
  end

  assign busy        = active;
  assign done        = done_q;
  assign position    = (act_q == tsst_pkg::ACT_QUERY) ? nxt : cur;
  assign slot_state  = state_q;
  assign flag        = flag_q;
  assign end_of_tray = eot_q;
  assign index_error = err_q;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer running");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start the sequencer");

  a_eot_no_err: assert property (@(posedge clk) disable iff (rst)
    end_of_tray |-> !index_error)
    else $error("end of tray together with index error");

  a_state_alone: assert property (@(posedge clk) disable iff (rst)
    (slot_state != '0) |-> (!flag && !end_of_tray && !index_error))
    else $error("status read mixed with other result flags");

  a_write_bound: assert property (@(posedge clk) disable iff (rst)
    (st_wr && w.addr_sel != tsst_pkg::A_PTR) |-> !bad)
    else $error("slot write beyond slot count");

endmodule
